@@ src/ttfv_pkg.sv @@
`timescale 1ns / 1ps

package ttfv_pkg;

   typedef enum logic [2:0] {
      MODE_INT32     = 3'd0,
      MODE_INT16     = 3'd1,
      MODE_INT64     = 3'd2,
      MODE_FLOAT     = 3'd3,
      MODE_DIGIT_BOOL = 3'd4,
      MODE_TEXT_BOOL = 3'd5,
      MODE_VECTOR3   = 3'd6,
      MODE_ANY       = 3'd7
   } mode_type;

   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_PERIOD = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_ONE    = 8'h31;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   localparam int MAG_WIDTH = 33;
   localparam logic [MAG_WIDTH-1:0] MAG_CAP       = 33'h1_0000_0000;
   localparam logic [MAG_WIDTH-1:0] INT32_POS_MAX = 33'h0_7FFF_FFFF;
   localparam logic [MAG_WIDTH-1:0] INT32_NEG_MAX = 33'h0_8000_0000;
   localparam logic [MAG_WIDTH-1:0] INT16_POS_MAX = 33'h0_0000_7FFF;
   localparam logic [MAG_WIDTH-1:0] INT16_NEG_MAX = 33'h0_0000_8000;

   localparam logic [2:0] COUNT_MAX      = 3'd7;
   localparam logic [2:0] VEC3_MIN_COUNT = 3'd6;
   localparam logic [1:0] VEC3_COMMAS    = 2'd2;

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
   endfunction

   function automatic logic [7:0] true_char(input logic [1:0] idx);
      logic [7:0] ch;
      case (idx)
         2'd0: ch = 8'h74;
         2'd1: ch = 8'h72;
         2'd2: ch = 8'h75;
         default: ch = 8'h65;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] false_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0: ch = 8'h66;
         3'd1: ch = 8'h61;
         3'd2: ch = 8'h6C;
         3'd3: ch = 8'h73;
         default: ch = 8'h65;
      endcase
      return ch;
   endfunction

endpackage

@@ src/typed_text_field_validator.sv @@
`timescale 1ns / 1ps

// Typed text field validator.
// Request channel (req_*): one character of a text field per transfer, with
// the field's type mode, a last flag and an empty flag (no character). The
// mode of the first non-empty transfer of a field applies to the whole field.
// Response channel (rsp_*): one transfer per field, carrying rsp_valid_res,
// which is high when the field is well formed for its mode.
// The response is registered and valid in the cycle after the transfer marked last.
// Throughput: one character per cycle while req_stall is low; the character
// update and the field check are a single registered step (the widest path is
// the times-ten accumulate and range compare of the integer modes).
// Stall: the response sits in an output register. While it is held by
// rsp_stall, req_stall rises and no new character is taken; otherwise the
// request side keeps moving even when a response is pending.
// Reset: synchronous, active high; clears all field state and drops rsp_valid.
module typed_text_field_validator
   import ttfv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_mode,
   input  logic [7:0] req_character,
   input  logic       req_last,
   input  logic       req_empty_req,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_valid_res
);

   logic [2:0]           field_mode_ff, field_mode_in;
   logic [2:0]           char_count_ff, char_count_in;
   logic                 negative_ff, negative_in;
   logic                 period_ff, period_in;
   logic                 comma_ff, comma_in;
   logic                 bad_ff, bad_in;
   logic [MAG_WIDTH-1:0] magnitude_ff, magnitude_in;
   logic [3:0]           segment_ff, segment_in;
   logic [1:0]           comma_total_ff, comma_total_in;
   logic [1:0]           word_match_ff, word_match_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_res_ff, rsp_res_in;

   logic                 req_take;
   logic                 absorb;
   logic [2:0]           cur_mode;
   logic [1:0]           seg_len;
   logic [2:0]           seg_need;
   logic [MAG_WIDTH+3:0] mag_next;
   logic [1:0]           fin_len;
   logic [2:0]           fin_need;
   logic                 fin_seg_bad;
   logic [2:0]           need;
   logic                 verdict;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;
   assign absorb    = req_take & ~req_empty_req;
   assign cur_mode  = (char_count_ff == 3'd0) ? req_mode : field_mode_ff;
   assign seg_len   = segment_ff[1:0];
   assign seg_need  = 3'd1 + {2'b00, segment_ff[3]} + {2'b00, segment_ff[2]};
   assign mag_next  = {1'b0, magnitude_ff, 3'b000} + {3'b000, magnitude_ff, 1'b0}
                    + {33'd0, req_character[3:0] - CHAR_ZERO[3:0]};

   // Character update.
   always_comb begin
      field_mode_in  = cur_mode;
      char_count_in  = char_count_ff;
      negative_in    = negative_ff;
      period_in      = period_ff;
      comma_in       = comma_ff;
      bad_in         = bad_ff;
      magnitude_in   = magnitude_ff;
      segment_in     = segment_ff;
      comma_total_in = comma_total_ff;
      word_match_in  = word_match_ff;
      if (absorb) begin
         case (cur_mode)
            MODE_INT32, MODE_INT16, MODE_INT64, MODE_FLOAT: begin
               // text after the first comma is counted only
               if (comma_ff) begin
                  comma_in = 1'b1;
               end else if (char_count_ff == 3'd0 && req_character == CHAR_MINUS) begin
                  negative_in = 1'b1;
               end else if (req_character == CHAR_COMMA) begin
                  comma_in = 1'b1;
               end else if (req_character == CHAR_PERIOD && cur_mode == MODE_FLOAT) begin
                  if (period_ff) bad_in = 1'b1;
                  period_in = 1'b1;
               end else if (is_digit(req_character)) begin
                  if (mag_next > {4'd0, MAG_CAP}) magnitude_in = MAG_CAP;
                  else magnitude_in = mag_next[MAG_WIDTH-1:0];
               end else begin
                  bad_in = 1'b1;
               end
            end
            MODE_DIGIT_BOOL: begin
               if (req_character != CHAR_ZERO && req_character != CHAR_ONE) bad_in = 1'b1;
            end
            MODE_TEXT_BOOL: begin
               if (char_count_ff >= 3'd4 || req_character != true_char(char_count_ff[1:0]))
                  word_match_in[0] = 1'b0;
               if (char_count_ff >= 3'd5 || req_character != false_char(char_count_ff))
                  word_match_in[1] = 1'b0;
            end
            MODE_VECTOR3: begin
               if (req_character == CHAR_COMMA) begin
                  // close the part
                  if (seg_len == 2'd0 || {1'b0, seg_len} < seg_need) bad_in = 1'b1;
                  segment_in = 4'd0;
                  if (comma_total_ff != 2'd3) comma_total_in = comma_total_ff + 2'd1;
               end else begin
                  if (seg_len == 2'd0 && req_character == CHAR_MINUS) begin
                     segment_in[2] = 1'b1;
                  end else if (req_character == CHAR_PERIOD) begin
                     if (segment_ff[3]) bad_in = 1'b1;
                     segment_in[3] = 1'b1;
                  end else if (!is_digit(req_character)) begin
                     bad_in = 1'b1;
                  end
                  if (seg_len != 2'd3) segment_in[1:0] = seg_len + 2'd1;
               end
            end
            default: begin
            end
         endcase
         if (char_count_ff != COUNT_MAX) char_count_in = char_count_ff + 3'd1;
      end
   end

   // Field check on the updated state.
   assign fin_len     = segment_in[1:0];
   assign fin_need    = 3'd1 + {2'b00, segment_in[3]} + {2'b00, segment_in[2]};
   assign fin_seg_bad = (fin_len == 2'd0) || ({1'b0, fin_len} < fin_need);
   assign need        = 3'd1 + {2'b00, negative_in};

   always_comb begin
      case (cur_mode)
         MODE_INT32: verdict = !bad_in && char_count_in >= need
                       && (negative_in ? magnitude_in <= INT32_NEG_MAX
                                       : magnitude_in <= INT32_POS_MAX);
         MODE_INT16: verdict = !bad_in && char_count_in >= need
                       && (negative_in ? magnitude_in <= INT16_NEG_MAX
                                       : magnitude_in <= INT16_POS_MAX);
         MODE_INT64: verdict = !bad_in && char_count_in >= need;
         MODE_FLOAT: verdict = !bad_in && char_count_in >= need + {2'b00, period_in};
         MODE_DIGIT_BOOL: verdict = !bad_in && char_count_in == 3'd1;
         MODE_TEXT_BOOL: verdict = word_match_in != 2'b00;
         MODE_VECTOR3: verdict = !bad_in && !fin_seg_bad && comma_total_in == VEC3_COMMAS
                       && char_count_in >= VEC3_MIN_COUNT;
         default: verdict = 1'b1;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_res_in   = rsp_res_ff;
      if (req_take && req_last) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (req_take && req_last)) begin
         field_mode_ff  <= 3'd0;
         char_count_ff  <= 3'd0;
         negative_ff    <= 1'b0;
         period_ff      <= 1'b0;
         comma_ff       <= 1'b0;
         bad_ff         <= 1'b0;
         magnitude_ff   <= '0;
         segment_ff     <= 4'd0;
         comma_total_ff <= 2'd0;
         word_match_ff  <= 2'b11;
      end else if (req_take) begin
         field_mode_ff  <= field_mode_in;
         char_count_ff  <= char_count_in;
         negative_ff    <= negative_in;
         period_ff      <= period_in;
         comma_ff       <= comma_in;
         bad_ff         <= bad_in;
         magnitude_ff   <= magnitude_in;
         segment_ff     <= segment_in;
         comma_total_ff <= comma_total_in;
         word_match_ff  <= word_match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_res_ff;

endmodule

@@ src/ttfv_checker.sv @@
`timescale 1ns / 1ps

module ttfv_checker
   import ttfv_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_valid_res
);

   // hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_valid_res))
      else $error("stalled response changed");

   // a field end yields a response in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last |=> rsp_valid)
      else $error("missing response after last transfer");

   // a mid-field character yields no response
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_last && !(rsp_valid && rsp_stall) |=> !rsp_valid)
      else $error("response without field end");

   // stall the request side only behind a held response
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without backpressure");

endmodule

bind typed_text_field_validator ttfv_checker u_ttfv_checker (.*);

@@ tb/ttfv_checker.sv @@
`timescale 1ns / 1ps

module ttfv_scoreboard
   import ttfv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [2:0] req_mode,
   input  logic [7:0] req_character,
   input  logic       req_last,
   input  logic       req_empty_req,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_valid_res,
   output int         mismatch_count,
   output int         verdicts_pending,
   output int         verdicts_checked,
   output int         verdicts_true
);

   localparam logic [31:0] TRUE_WORD  = "true";
   localparam logic [39:0] FALSE_WORD = "false";

   mode_type             cur_mode;
   logic [2:0]           seen_count;
   logic                 minus_flag;
   logic                 point_flag;
   logic                 comma_flag;
   logic                 error_flag;
   logic [MAG_WIDTH-1:0] mag_acc;
   logic [4:0]           part_state;
   logic [1:0]           part_commas;
   logic [1:0]           word_alive;
   logic                 expected_verdicts[$];

   task automatic clear_field();
      cur_mode    = MODE_INT32;
      seen_count  = '0;
      minus_flag  = 1'b0;
      point_flag  = 1'b0;
      comma_flag  = 1'b0;
      error_flag  = 1'b0;
      mag_acc     = '0;
      part_state  = '0;
      part_commas = '0;
      word_alive  = 2'b11;
   endtask

   // A vector3 part needs a digit beyond its optional sign and period.
   task automatic close_part();
      logic [1:0] len;
      logic [1:0] need;
      len  = part_state[1:0];
      need = 2'd1 + {1'b0, part_state[3]} + {1'b0, part_state[2]};
      if (len == 2'd0 || len < need) error_flag = 1'b1;
      part_state = '0;
   endtask

   task automatic absorb_char(input logic [7:0] ch);
      logic [36:0] wide;
      logic [1:0]  len;
      logic [7:0]  want_t;
      logic [7:0]  want_f;
      int          idx;
      idx = int'(seen_count);
      case (cur_mode)
         MODE_INT32, MODE_INT16, MODE_INT64, MODE_FLOAT: begin
            // Characters after the first comma are counted only.
            if (!comma_flag) begin
               if (idx == 0 && ch == CHAR_MINUS) begin
                  minus_flag = 1'b1;
               end else if (ch == CHAR_COMMA) begin
                  comma_flag = 1'b1;
               end else if (ch == CHAR_PERIOD && cur_mode == MODE_FLOAT) begin
                  if (point_flag) error_flag = 1'b1;
                  point_flag = 1'b1;
               end else if (ch inside {[CHAR_ZERO:CHAR_NINE]}) begin
                  wide = 37'(mag_acc) * 37'd10 + 37'(ch - CHAR_ZERO);
                  mag_acc = (wide > 37'(MAG_CAP)) ? MAG_CAP : wide[MAG_WIDTH-1:0];
               end else begin
                  error_flag = 1'b1;
               end
            end
         end
         MODE_DIGIT_BOOL: begin
            if (ch != CHAR_ZERO && ch != CHAR_ONE) error_flag = 1'b1;
         end
         MODE_TEXT_BOOL: begin
            want_t = (idx < 4) ? TRUE_WORD[8*(3-idx) +: 8] : 8'h00;
            want_f = (idx < 5) ? FALSE_WORD[8*(4-idx) +: 8] : 8'h00;
            if (idx >= 4 || ch != want_t) word_alive[0] = 1'b0;
            if (idx >= 5 || ch != want_f) word_alive[1] = 1'b0;
         end
         MODE_VECTOR3: begin
            if (ch == CHAR_COMMA) begin
               close_part();
               if (part_commas != 2'd3) part_commas++;
            end else begin
               len = part_state[1:0];
               if (len == 2'd0 && ch == CHAR_MINUS) begin
                  part_state[2] = 1'b1;
               end else if (ch == CHAR_PERIOD) begin
                  if (part_state[3]) error_flag = 1'b1;
                  part_state[3] = 1'b1;
               end else if (!(ch inside {[CHAR_ZERO:CHAR_NINE]})) begin
                  error_flag = 1'b1;
               end
               if (len != 2'd3) part_state[1:0] = len + 2'd1;
            end
         end
         default: begin
         end
      endcase
      if (seen_count != COUNT_MAX) seen_count++;
   endtask

   task automatic field_verdict(output logic ok);
      logic [2:0] need;
      need = 3'd1 + {2'b00, minus_flag};
      case (cur_mode)
         MODE_INT32:
            ok = !error_flag && seen_count >= need &&
                 (minus_flag ? mag_acc <= INT32_NEG_MAX : mag_acc <= INT32_POS_MAX);
         MODE_INT16:
            ok = !error_flag && seen_count >= need &&
                 (minus_flag ? mag_acc <= INT16_NEG_MAX : mag_acc <= INT16_POS_MAX);
         MODE_INT64:      ok = !error_flag && seen_count >= need;
         MODE_FLOAT:      ok = !error_flag && seen_count >= need + {2'b00, point_flag};
         MODE_DIGIT_BOOL: ok = !error_flag && seen_count == 3'd1;
         MODE_TEXT_BOOL:  ok = word_alive != 2'b00;
         MODE_VECTOR3: begin
            close_part();
            ok = !error_flag && part_commas == VEC3_COMMAS && seen_count >= VEC3_MIN_COUNT;
         end
         default:         ok = 1'b1;
      endcase
   endtask

   always @(posedge clock) begin : watch
      logic ok;
      logic want;
      if (reset) begin
         clear_field();
         expected_verdicts.delete();
         mismatch_count   = 0;
         verdicts_checked = 0;
         verdicts_true    = 0;
      end else begin
         // Retire the response first: it can never belong to this edge's request.
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               $error("valid_res: expected no transfer, actual %0b", rsp_valid_res);
               mismatch_count++;
            end else begin
               want = expected_verdicts.pop_front();
               verdicts_checked++;
               if (want) verdicts_true++;
               if (rsp_valid_res !== want) begin
                  $error("valid_res: expected %0b, actual %0b", want, rsp_valid_res);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (seen_count == 3'd0) cur_mode = mode_type'(req_mode);
            if (!req_empty_req) absorb_char(req_character);
            if (req_last) begin
               field_verdict(ok);
               expected_verdicts.push_back(ok);
               clear_field();
            end
         end
      end
      verdicts_pending = expected_verdicts.size();
   end

endmodule

@@ tb/tb_typed_text_field_validator.sv @@
`timescale 1ns / 1ps

module tb_typed_text_field_validator;
   import ttfv_pkg::*;

   typedef logic [7:0] text_type[$];

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_stall;
   logic [2:0] req_mode      = 3'd0;
   logic [7:0] req_character = 8'd0;
   logic       req_last      = 1'b0;
   logic       req_empty_req = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall     = 1'b0;
   logic       rsp_valid_res;

   int mismatch_count;
   int verdicts_pending;
   int verdicts_checked;
   int verdicts_true;

   int idle_pct     = 0;
   int stall_pct    = 0;
   int hold_request = 0;
   int items_sent   = 0;
   int fields_sent  = 0;

   typed_text_field_validator dut (.*);

   ttfv_scoreboard field_check (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   // Response side: random stall, or a long hold when one is requested.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   task automatic send_item(input logic [2:0] mode, input logic [7:0] ch,
                            input logic lst, input logic emp);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_character <= ch;
      req_last      <= lst;
      req_empty_req <= emp;
      do @(posedge clock); while (req_stall);
      if (!(emp && !lst)) items_sent++;
      @(negedge clock);
   endtask

   // Mixed-up fields get stray empty transfers and random modes after the first.
   task automatic send_text(input mode_type m, input text_type text, input bit end_empty,
                            input bit scramble);
      int         n;
      logic [2:0] md;
      n = text.size();
      for (int i = 0; i < n; i++) begin
         if (scramble && $urandom_range(9) == 0)
            send_item(3'($urandom_range(7)), 8'($urandom), 1'b0, 1'b1);
         md = (i > 0 && scramble) ? 3'($urandom_range(7)) : m;
         send_item(md, text[i], (i == n - 1) && !end_empty, 1'b0);
      end
      if (n == 0 || end_empty) send_item(m, 8'($urandom), 1'b1, 1'b1);
      fields_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (verdicts_pending != 0) @(negedge clock);
   endtask

   function automatic text_type to_text(input string s);
      text_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   function automatic logic [7:0] pick_char();
      string alphabet;
      alphabet = "-,.0123456789truefals";
      if ($urandom_range(2) == 0) return 8'($urandom);
      return alphabet[$urandom_range(alphabet.len() - 1)];
   endfunction

   function automatic string digits(input int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = $sformatf("%s%0d", s, $urandom_range(9));
      return s;
   endfunction

   function automatic text_type noise_text();
      text_type q;
      int       n;
      n = $urandom_range(9);
      for (int i = 0; i < n; i++) q.push_back(pick_char());
      return q;
   endfunction

   function automatic string part_text();
      string s;
      s = {($urandom_range(3) == 0) ? "-" : "", digits($urandom_range(2))};
      if ($urandom_range(2) == 0) s = {s, ".", digits($urandom_range(1))};
      return s;
   endfunction

   // Mostly well-formed text for the mode, with boundary values near the ranges.
   function automatic text_type shaped_text(input mode_type m);
      longint unsigned v;
      string           s;
      string           w;
      int              parts;
      case (m)
         MODE_INT32, MODE_INT16, MODE_INT64: begin
            case ($urandom_range(5))
               0:       v = 64'd32766 + $urandom_range(3);
               1:       v = 64'h7FFF_FFFE + $urandom_range(3);
               2:       v = 64'hFFFF_FFFE + $urandom_range(3);
               3:       v = $urandom_range(999);
               4:       v = {$urandom, $urandom};
               default: v = $urandom;
            endcase
            s = $sformatf("%0d", v);
            if ($urandom_range(9) == 0) s = {"0", s};
            if ($urandom_range(1) == 1) s = {"-", s};
            if ($urandom_range(7) == 0) s = {s, ",", digits(2)};
            if ($urandom_range(15) == 0) s = ($urandom_range(1) == 1) ? "-" : "";
         end
         MODE_FLOAT: begin
            s = {($urandom_range(1) == 1) ? "-" : "", digits($urandom_range(3))};
            if ($urandom_range(3) != 0) s = {s, ".", digits($urandom_range(3))};
            if ($urandom_range(7) == 0) s = {s, "."};
            if ($urandom_range(9) == 0) s = {s, ",", digits(1)};
         end
         MODE_DIGIT_BOOL: begin
            case ($urandom_range(3))
               0:       s = "0";
               1:       s = "1";
               2:       s = {digits(1), digits(1)};
               default: s = digits(1);
            endcase
         end
         MODE_TEXT_BOOL: begin
            w = ($urandom_range(1) == 1) ? "true" : "false";
            s = w.substr(0, $urandom_range(w.len()) - 1);
            if ($urandom_range(5) == 0) s = {s, "e"};
         end
         MODE_VECTOR3: begin
            parts = ($urandom_range(4) == 0) ? 2 + 2 * $urandom_range(1) : 3;
            s = part_text();
            for (int i = 1; i < parts; i++) s = {s, ",", part_text()};
         end
         default: return noise_text();
      endcase
      return to_text(s);
   endfunction

   task automatic random_fields(input int item_goal);
      int       stop;
      mode_type m;
      text_type t;
      stop = items_sent + item_goal;
      while (items_sent < stop) begin
         m = mode_type'($urandom_range(7));
         if ($urandom_range(3) == 0) begin
            send_text(m, noise_text(), $urandom_range(1), 1'b1);
         end else begin
            t = shaped_text(m);
            if (t.size() > 0 && $urandom_range(7) == 0)
               t[$urandom_range(t.size() - 1)] = pick_char();
            send_text(m, t, $urandom_range(5) == 0, 1'b0);
         end
      end
   endtask

   initial begin : stimulus
      text_type bytes;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Range edges, misplaced minus, empty field and out-of-alphabet bytes.
      send_text(MODE_INT16, to_text("-32768"), 1'b0, 1'b0);
      send_text(MODE_INT16, to_text("32768"), 1'b0, 1'b0);
      send_text(MODE_FLOAT, to_text("-1."), 1'b0, 1'b0);
      send_item(MODE_DIGIT_BOOL, 8'hFF, 1'b0, 1'b1);
      send_text(MODE_DIGIT_BOOL, to_text("1"), 1'b0, 1'b0);
      send_text(MODE_TEXT_BOOL, to_text(""), 1'b0, 1'b0);
      send_text(MODE_VECTOR3, to_text("1,2,3"), 1'b0, 1'b0);
      send_text(MODE_INT32, to_text("1-"), 1'b0, 1'b0);
      bytes = '{8'h00, 8'hFF};
      send_text(MODE_ANY, bytes, 1'b0, 1'b0);
      drain();

      idle_pct  = 0;
      stall_pct = 0;
      random_fields(150);
      drain();

      // Hold the response side off while the request side keeps pushing.
      @(posedge clock);
      hold_request = 300;
      @(negedge clock);
      random_fields(60);
      drain();

      idle_pct  = 87;
      stall_pct = 0;
      random_fields(120);
      drain();

      idle_pct  = 0;
      stall_pct = 87;
      random_fields(120);
      drain();

      idle_pct  = 15;
      stall_pct = 15;
      random_fields(150);

      req_valid <= 1'b0;
      for (int n = 0; n < 5000 && verdicts_pending != 0; n++) @(negedge clock);
      repeat (4) @(negedge clock);
      if (verdicts_pending != 0)
         $error("valid_res: %0d expected transfers never arrived", verdicts_pending);

      $display("Run covered %0d request transfers in %0d fields over all eight modes,",
               items_sent, fields_sent);
      $display("with %0d verdicts checked (%0d valid) under idle, stall and long-hold phases.",
               verdicts_checked, verdicts_true);
      if (mismatch_count == 0 && verdicts_pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
